// File: design/lts_pkg.sv
// ----------------------------------------------------------------------------
// Loser-tree select package
// Shared operation codes, configuration constants and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int OP_W       = 2;
  localparam int WAY_PORT_W = 3;
  localparam int KEY_PORT_W = 64;
  localparam int CFG_W      = 4;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLAY = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic load_head;
    logic start_build;
    logic start_replay;
    logic bd_key;
    logic bd_cmp;
    logic rp_key;
    logic rp_cmp;
    logic finish;
    logic cfg_write;
  } cmd_t;

  typedef struct packed {
    logic node_last;
  } sts_t;

endpackage

// File: design/lts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lts_ctrl.sv
// ----------------------------------------------------------------------------
// Loser-tree select controller
// Sequences loads, tournament builds and replays, and owns the handshakes.
// ----------------------------------------------------------------------------
module lts_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lts_pkg::OP_W-1:0]      op_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  output lts_pkg::cmd_t                 cmd_o,
  input  lts_pkg::sts_t                 sts_i
);
  import lts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BD_RD,
    S_BD_KEY,
    S_BD_CMP,
    S_RP_RD,
    S_RP_KEY,
    S_RP_CMP,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   built_q;
  logic   idle;
  logic   in_acc;

  assign idle        = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && idle;
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o              = '0;
    cmd_o.load_head    = in_acc && (op_i == OP_LOAD);
    cmd_o.start_build  = in_acc && (op_i == OP_BUILD);
    cmd_o.start_replay = in_acc && (op_i == OP_REPLAY) && built_q;
    cmd_o.bd_key       = (state_q == S_BD_KEY);
    cmd_o.bd_cmp       = (state_q == S_BD_CMP);
    cmd_o.rp_key       = (state_q == S_RP_KEY);
    cmd_o.rp_cmp       = (state_q == S_RP_CMP);
    cmd_o.finish       = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
    cmd_o.cfg_write    = cfg_valid_i && idle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      built_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (op_i)
              OP_BUILD:  state_q <= S_BD_RD;
              OP_REPLAY: state_q <= built_q ? S_RP_RD : S_IDLE;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_BD_RD:  state_q <= S_BD_KEY;
        S_BD_KEY: state_q <= S_BD_CMP;
        S_BD_CMP: state_q <= sts_i.node_last ? S_FIN : S_BD_RD;
        S_RP_RD:  state_q <= S_RP_KEY;
        S_RP_KEY: state_q <= S_RP_CMP;
        S_RP_CMP: state_q <= sts_i.node_last ? S_FIN : S_RP_RD;
        S_FIN: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      priority if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end else begin
        out_valid_q <= out_valid_q;
      end

      priority if (cmd_o.cfg_write) begin
        built_q <= 1'b0;
      end else if (cmd_o.start_build) begin
        built_q <= 1'b1;
      end else begin
        built_q <= built_q;
      end
    end
  end

  a_replay_needs_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == OP_REPLAY) && !built_q |=> state_q == S_IDLE)
    else $error("replay started without a built tree");

  a_finish_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q && state_q == S_IDLE)
    else $error("finished result not presented");

endmodule

// File: design/lts_dpath.sv
// ----------------------------------------------------------------------------
// Loser-tree select datapath
// Way heads, inner-node losers and build champions in RAM, one shared key
// comparator, the candidate register and the result register.
// ----------------------------------------------------------------------------
module lts_dpath #(
  parameter int NUM_WAYS  = 8,
  parameter int KEY_WIDTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lts_pkg::cmd_t                     cmd_i,
  output lts_pkg::sts_t                     sts_o,
  input  logic [lts_pkg::WAY_PORT_W-1:0]    way_i,
  input  logic [lts_pkg::KEY_PORT_W-1:0]    head_key_i,
  input  logic                              key_valid_i,
  input  logic [lts_pkg::CFG_W-1:0]         ways_in_use_i,
  output logic [lts_pkg::WAY_PORT_W-1:0]    winner_way_o,
  output logic [lts_pkg::KEY_PORT_W-1:0]    winner_key_o,
  output logic                              winner_valid_o
);
  import lts_pkg::*;

  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int POS_W = WAY_W + 1;
  localparam int ENT_W = KEY_WIDTH + 1;
  localparam logic [7:0] WAYS_B = 8'(NUM_WAYS);

  logic [CFG_W-1:0]      ways_q;
  logic [7:0]            cfg_b;
  logic [7:0]            n_b;
  logic [POS_W-1:0]      n;

  logic [POS_W-1:0]      node_q;
  logic [WAY_W-1:0]      cand_w_q;
  logic [KEY_WIDTH-1:0]  cand_key_q;
  logic                  cand_vld_q;
  logic [WAY_W-1:0]      l_q;
  logic [WAY_W-1:0]      r_q;
  logic [WAY_W-1:0]      st_q;
  logic [WAY_W-1:0]      win_q;
  logic [WAY_PORT_W-1:0] out_way_q;
  logic [KEY_PORT_W-1:0] out_key_q;
  logic                  out_vld_q;

  logic [POS_W-1:0]      lpos;
  logic [POS_W-1:0]      rpos;
  logic [WAY_W-1:0]      l_d;
  logic [WAY_W-1:0]      r_d;
  logic                  way_ok;

  logic                  key_we;
  logic [WAY_W-1:0]      key_waddr;
  logic [ENT_W-1:0]      key_wdata;
  logic [WAY_W-1:0]      key_a_raddr;
  logic [ENT_W-1:0]      key_a_rd;
  logic [ENT_W-1:0]      key_b_rd;

  logic [WAY_W-1:0]      champ_wdata;
  logic [WAY_W-1:0]      champ_a_rd;
  logic [WAY_W-1:0]      champ_b_rd;

  logic                  lsr_we;
  logic [WAY_W-1:0]      lsr_wdata;
  logic [WAY_W-1:0]      lsr_rd;

  logic [ENT_W-1:0]      cmp_a;
  logic [ENT_W-1:0]      cmp_b;
  logic                  a_beats;

  assign cfg_b = {4'd0, ways_q};
  assign n_b   = (cfg_b < 8'd2) ? 8'd2 : ((cfg_b > WAYS_B) ? WAYS_B : cfg_b);
  assign n     = POS_W'(n_b);

  assign sts_o.node_last = (node_q == POS_W'(1));

  assign lpos = {node_q[WAY_W-1:0], 1'b0};
  assign rpos = {node_q[WAY_W-1:0], 1'b1};
  assign l_d  = (lpos >= n) ? WAY_W'(lpos - n) : champ_a_rd;
  assign r_d  = (rpos >= n) ? WAY_W'(rpos - n) : champ_b_rd;

  assign way_ok    = ({5'd0, way_i} < WAYS_B);
  assign key_we    = (cmd_i.load_head && way_ok) || cmd_i.start_replay;
  assign key_waddr = cmd_i.start_replay ? win_q : WAY_W'(way_i);
  assign key_wdata = {key_valid_i, head_key_i[KEY_WIDTH-1:0]};
  assign key_a_raddr = cmd_i.bd_key ? l_d : lsr_rd;

  assign cmp_a   = cmd_i.rp_cmp ? {cand_vld_q, cand_key_q} : key_a_rd;
  assign cmp_b   = cmd_i.rp_cmp ? key_a_rd : key_b_rd;
  assign a_beats = cmp_a[KEY_WIDTH] &&
                   (!cmp_b[KEY_WIDTH] || (cmp_a[KEY_WIDTH-1:0] < cmp_b[KEY_WIDTH-1:0]));

  assign champ_wdata = a_beats ? l_q : r_q;
  assign lsr_we      = cmd_i.bd_cmp || (cmd_i.rp_cmp && !a_beats);
  assign lsr_wdata   = cmd_i.bd_cmp ? (a_beats ? r_q : l_q) : cand_w_q;

  lts_ram #(.WIDTH(ENT_W), .DEPTH(NUM_WAYS)) u_key_a (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_a_raddr),
    .rdata_o (key_a_rd)
  );

  lts_ram #(.WIDTH(ENT_W), .DEPTH(NUM_WAYS)) u_key_b (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (r_d),
    .rdata_o (key_b_rd)
  );

  lts_ram #(.WIDTH(WAY_W), .DEPTH(NUM_WAYS)) u_champ_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.bd_cmp),
    .waddr_i (node_q[WAY_W-1:0]),
    .wdata_i (champ_wdata),
    .raddr_i (lpos[WAY_W-1:0]),
    .rdata_o (champ_a_rd)
  );

  lts_ram #(.WIDTH(WAY_W), .DEPTH(NUM_WAYS)) u_champ_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.bd_cmp),
    .waddr_i (node_q[WAY_W-1:0]),
    .wdata_i (champ_wdata),
    .raddr_i (rpos[WAY_W-1:0]),
    .rdata_o (champ_b_rd)
  );

  lts_ram #(.WIDTH(WAY_W), .DEPTH(NUM_WAYS)) u_loser (
    .clk_i   (clk_i),
    .we_i    (lsr_we),
    .waddr_i (node_q[WAY_W-1:0]),
    .wdata_i (lsr_wdata),
    .raddr_i (node_q[WAY_W-1:0]),
    .rdata_o (lsr_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= CFG_RESET;
      node_q <= '0;
      win_q  <= '0;
    end else begin
      if (cmd_i.cfg_write) begin
        ways_q <= ways_in_use_i;
      end
      priority if (cmd_i.start_build) begin
        node_q <= n - POS_W'(1);
      end else if (cmd_i.start_replay) begin
        node_q <= (POS_W'(win_q) + n) >> 1;
      end else if (cmd_i.bd_cmp) begin
        node_q <= node_q - POS_W'(1);
      end else if (cmd_i.rp_cmp) begin
        node_q <= node_q >> 1;
      end else begin
        node_q <= node_q;
      end
      if (cmd_i.finish) begin
        win_q <= cand_w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bd_key) begin
      l_q <= l_d;
      r_q <= r_d;
    end
    if (cmd_i.rp_key) begin
      st_q <= lsr_rd;
    end
    priority if (cmd_i.start_replay) begin
      cand_w_q   <= win_q;
      cand_key_q <= head_key_i[KEY_WIDTH-1:0];
      cand_vld_q <= key_valid_i;
    end else if (cmd_i.bd_cmp) begin
      if (a_beats) begin
        cand_w_q   <= l_q;
        cand_key_q <= key_a_rd[KEY_WIDTH-1:0];
        cand_vld_q <= key_a_rd[KEY_WIDTH];
      end else begin
        cand_w_q   <= r_q;
        cand_key_q <= key_b_rd[KEY_WIDTH-1:0];
        cand_vld_q <= key_b_rd[KEY_WIDTH];
      end
    end else if (cmd_i.rp_cmp && !a_beats) begin
      cand_w_q   <= st_q;
      cand_key_q <= key_a_rd[KEY_WIDTH-1:0];
      cand_vld_q <= key_a_rd[KEY_WIDTH];
    end else begin
      cand_w_q   <= cand_w_q;
      cand_key_q <= cand_key_q;
      cand_vld_q <= cand_vld_q;
    end
    if (cmd_i.finish) begin
      out_way_q <= WAY_PORT_W'(cand_w_q);
      out_key_q <= cand_vld_q ? KEY_PORT_W'(cand_key_q) : '0;
      out_vld_q <= cand_vld_q;
    end
  end

  assign winner_way_o   = out_way_q;
  assign winner_key_o   = out_key_q;
  assign winner_valid_o = out_vld_q;

  a_build_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bd_cmp |-> (node_q != '0) && (node_q < n))
    else $error("build visited a node outside the tree");

  a_replay_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rp_cmp |-> node_q != '0)
    else $error("replay compared above the root");

  a_replay_starts_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_replay |=> (node_q != '0) && (node_q < n))
    else $error("replay started outside the tree");

endmodule

// File: design/loser_tree_merge_select.sv
// ----------------------------------------------------------------------------
// Loser-tree merge select
// Tournament selector for a k-way merge: loads way heads, builds the loser
// tree and replays the winner's path after its head is replaced.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o   op_i, way_i, head_key_i,
//                                               key_valid_i
//   out      output     out_valid_o/out_stall_i winner_way_o, winner_key_o,
//                                               winner_valid_o
//   cfg      input      cfg_valid_i/cfg_ready_o ways_in_use_i
//
// A build steps through each of the n-1 inner nodes and a replay through each
// tree level on the winner's path, and both then pass through a finish state,
// where n is the number of ways in use; each level or node is a RAM read of
// the stored loser or champions, a RAM read of the keys, and one compare.
// One item is worked on at a time; the result register holds a transfer while
// out_stall_i is high. Reset leaves the tree unbuilt and n at eight.
// ----------------------------------------------------------------------------
module loser_tree_merge_select #(
  parameter int NUM_WAYS  = 8,
  parameter int KEY_WIDTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lts_pkg::OP_W-1:0]          op_i,
  input  logic [lts_pkg::WAY_PORT_W-1:0]    way_i,
  input  logic [lts_pkg::KEY_PORT_W-1:0]    head_key_i,
  input  logic                              key_valid_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lts_pkg::WAY_PORT_W-1:0]    winner_way_o,
  output logic [lts_pkg::KEY_PORT_W-1:0]    winner_key_o,
  output logic                              winner_valid_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lts_pkg::CFG_W-1:0]         ways_in_use_i
);
  import lts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lts_dpath #(
    .NUM_WAYS  (NUM_WAYS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .way_i          (way_i),
    .head_key_i     (head_key_i),
    .key_valid_i    (key_valid_i),
    .ways_in_use_i  (ways_in_use_i),
    .winner_way_o   (winner_way_o),
    .winner_key_o   (winner_key_o),
    .winner_valid_o (winner_valid_o)
  );

endmodule

// File: dv/tb_loser_tree_merge_select.sv
// ----------------------------------------------------------------------------
// Loser-tree merge select testbench
// Drives head loads, tree builds and winner replays into the selector and
// checks every reported winner against a tournament model kept in the bench.
// A short table of directed items opens the run, and random merge phases
// follow under several way counts. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_loser_tree_merge_select;
  import lts_pkg::*;

  localparam int NUM_WAYS = 8;
  localparam int ITEMS = 1050;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD = 300;
  localparam int LIMIT = 500000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  way;
    logic [63:0] key;
    logic        vld;
  } winner_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [OP_W-1:0] op;
    logic [2:0]      way;
    logic [63:0]     key;
    logic            kv;
    winner_t         want;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OP_W-1:0]       op_i;
  logic [WAY_PORT_W-1:0] way_i;
  logic [KEY_PORT_W-1:0] head_key_i;
  logic                  key_valid_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [WAY_PORT_W-1:0] winner_way_o;
  logic [KEY_PORT_W-1:0] winner_key_o;
  logic                  winner_valid_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      ways_in_use_i;

  loser_tree_merge_select #(
    .NUM_WAYS (NUM_WAYS),
    .KEY_WIDTH(64)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .way_i         (way_i),
    .head_key_i    (head_key_i),
    .key_valid_i   (key_valid_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .winner_way_o  (winner_way_o),
    .winner_key_o  (winner_key_o),
    .winner_valid_o(winner_valid_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .ways_in_use_i (ways_in_use_i)
  );

  logic [63:0]      mdl_key [NUM_WAYS];
  logic             mdl_vld [NUM_WAYS];
  logic [2:0]       mdl_loser [NUM_WAYS];
  logic             mdl_built = 1'b0;
  logic [CFG_W-1:0] mdl_cfg = CFG_RESET;

  winner_t pending[$];
  int      errors = 0;
  int      cycle_cnt = 0;
  int      items_done = 0;
  int      burst_left = 0;
  bit      steady = 1'b0;
  bit      hold_req = 1'b0;
  int      zero_pct = 10;

  step_t script [0:21] = '{
    '{ROW_ITEM,    OP_REPLAY, 3'd0, 64'd0,                   1'b1, '0},
    '{ROW_ITEM,    OP_UNUSED, 3'd0, 64'd0,                   1'b0, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd1, 64'd0,                   1'b1, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd2, 64'd5,                   1'b1, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd3, 64'd0,                   1'b1, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd4, 64'hDEAD_BEEF,           1'b0, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd5, 64'd100,                 1'b1, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd6, 64'h8000_0000_0000_0000, 1'b1, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd7, 64'd0,                   1'b1, '0},
    '{ROW_CHECKED, OP_BUILD,  3'd0, 64'd0,                   1'b0, '{3'd7, 64'd0, 1'b1}},
    '{ROW_ITEM,    OP_REPLAY, 3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{ROW_ITEM,    OP_REPLAY, 3'd2, 64'h1234,                1'b0, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd2, 64'd1,                   1'b1, '0},
    '{ROW_ITEM,    OP_REPLAY, 3'd0, 64'd3,                   1'b1, '0},
    '{ROW_ITEM,    OP_UNUSED, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
    '{ROW_CFG,     OP_LOAD,   3'd0, 64'd2,                   1'b0, '0},
    '{ROW_ITEM,    OP_REPLAY, 3'd1, 64'd7,                   1'b1, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd0, 64'd55,                  1'b0, '0},
    '{ROW_ITEM,    OP_LOAD,   3'd1, 64'd0,                   1'b0, '0},
    '{ROW_CHECKED, OP_BUILD,  3'd3, 64'd0,                   1'b1, '{3'd1, 64'd0, 1'b0}},
    '{ROW_ITEM,    OP_REPLAY, 3'd0, 64'd9,                   1'b0, '0}
  };

  function automatic int active_n();
    int n;
    n = int'(mdl_cfg);
    if (n < 2) n = 2;
    if (n > NUM_WAYS) n = NUM_WAYS;
    return n;
  endfunction

  function automatic bit wins(input int a, input int b);
    if (!mdl_vld[a]) return 1'b0;
    if (!mdl_vld[b]) return 1'b1;
    return mdl_key[a] < mdl_key[b];
  endfunction

  function automatic void rebuild_tree();
    int n, l, r;
    int champ [NUM_WAYS];
    n = active_n();
    champ = '{default: 0};
    for (int p = n - 1; p >= 1; p--) begin
      l = (2 * p >= n) ? 2 * p - n : champ[2 * p];
      r = (2 * p + 1 >= n) ? 2 * p + 1 - n : champ[2 * p + 1];
      if (wins(l, r)) begin
        mdl_loser[p] = 3'(r);
        champ[p] = l;
      end else begin
        mdl_loser[p] = 3'(l);
        champ[p] = r;
      end
    end
    mdl_loser[0] = 3'(champ[1]);
  endfunction

  function automatic void replay_path(input int w);
    int pos, held;
    pos = (w + active_n()) >> 1;
    while (pos > 0) begin
      held = int'(mdl_loser[pos]);
      if (!wins(w, held)) begin
        mdl_loser[pos] = 3'(w);
        w = held;
      end
      pos = pos >> 1;
    end
    mdl_loser[0] = 3'(w);
  endfunction

  function automatic bit predict_winner(input logic [OP_W-1:0] op, input logic [2:0] way,
                                        input logic [63:0] key, input logic kv,
                                        output winner_t res);
    logic [2:0] w;
    res = '0;
    case (op)
      OP_LOAD: begin
        mdl_key[way] = key;
        mdl_vld[way] = kv;
        return 1'b0;
      end
      OP_BUILD: begin
        rebuild_tree();
        mdl_built = 1'b1;
      end
      OP_REPLAY: begin
        if (!mdl_built) return 1'b0;
        w = mdl_loser[0];
        mdl_key[w] = key;
        mdl_vld[w] = kv;
        replay_path(int'(w));
      end
      default: return 1'b0;
    endcase
    w = mdl_loser[0];
    res.way = w;
    res.vld = mdl_vld[w];
    res.key = mdl_vld[w] ? mdl_key[w] : 64'd0;
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2, 3: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic rand_kv();
    return $urandom_range(0, 99) >= zero_pct;
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [2:0] way,
                           input logic [63:0] key, input logic kv,
                           input bit typed = 1'b0, input winner_t want = '0);
    winner_t got;
    bit      has;
    int      gap;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    way_i       <= way;
    head_key_i  <= key;
    key_valid_i <= kv;
    do @(posedge clk_i); while (in_stall_o);
    has = predict_winner(op, way, key, kv, got);
    if (has) pending.push_back(typed ? want : got);
    if (has || op == OP_LOAD) items_done++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = steady ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ways(input logic [CFG_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    ways_in_use_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    mdl_cfg   = val;
    mdl_built = 1'b0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    winner_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        flag_error($sformatf("unexpected transfer: way %0d key %h valid %b",
                             winner_way_o, winner_key_o, winner_valid_o));
      end else begin
        want = pending.pop_front();
        if (winner_way_o !== want.way || winner_key_o !== want.key ||
            winner_valid_o !== want.vld) begin
          flag_error($sformatf("expected way %0d key %h valid %b, got way %0d key %h valid %b",
                               want.way, want.key, want.vld,
                               winner_way_o, winner_key_o, winner_valid_o));
        end
      end
    end
  end

  initial begin
    int mode, left, hold_cnt;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(8, 60);
      end
      left--;
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] cfg_list [0:8];
    logic [CFG_W-1:0] cfg_val;
    int phase, reps;
    cfg_list      = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd2, 4'd9, 4'd5, 4'd3, 4'd7};
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_LOAD;
    way_i         = '0;
    head_key_i    = '0;
    key_valid_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    ways_in_use_i = CFG_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        write_ways(script[i].key[CFG_W-1:0]);
      end else begin
        send_item(script[i].op, script[i].way, script[i].key, script[i].kv,
                  script[i].kind == ROW_CHECKED, script[i].want);
      end
    end

    phase = 0;
    while (items_done < ITEMS) begin
      cfg_val = (phase < 9) ? cfg_list[phase] : CFG_W'($urandom_range(0, 15));
      write_ways(cfg_val);
      steady   = ($urandom_range(0, 3) == 0);
      zero_pct = ($urandom_range(0, 2) == 0) ? 35 : 8;
      if ($urandom_range(0, 3) == 0) begin
        send_item(OP_REPLAY, 3'($urandom_range(0, 7)), rand_key(), rand_kv());
      end
      for (int w = 0; w < active_n(); w++) begin
        send_item(OP_LOAD, 3'(w), rand_key(), rand_kv());
      end
      send_item(OP_BUILD, 3'($urandom_range(0, 7)), rand_key(), rand_kv());
      reps = $urandom_range(30, 90);
      for (int i = 0; i < reps; i++) begin
        if (phase == 1 && i == 10) hold_req = 1'b1;
        if (phase == 2 && i == 20) drain();
        case ($urandom_range(0, 19))
          0: send_item(OP_LOAD, 3'($urandom_range(0, 7)), rand_key(), rand_kv());
          1: send_item(OP_UNUSED, 3'($urandom_range(0, 7)), rand_key(), rand_kv());
          2: send_item(OP_BUILD, 3'($urandom_range(0, 7)), rand_key(), rand_kv());
          default: send_item(OP_REPLAY, 3'($urandom_range(0, 7)), rand_key(), rand_kv());
        endcase
      end
      phase++;
    end

    drain();
    if (pending.size() != 0) flag_error("transfers still outstanding at the end of the run");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
